/* src/prsm_pkg.sv */
package prsm_pkg;

  // Time base and reported time width
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned OUT_TIME_W     = 32;

  // Configuration register widths and port shape
  localparam int unsigned MARGIN_W    = 8;
  localparam int unsigned TIMER_W     = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SWITCH_MARGIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STOP      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RUN       = 2'd2;

  // Configuration reset values
  localparam logic [MARGIN_W-1:0] MARGIN_RST   = 8'd5;
  localparam logic [TIMER_W-1:0]  MIN_STOP_RST = 24'd6000;
  localparam logic [TIMER_W-1:0]  MAX_RUN_RST  = 24'd60000;

  // Event flag bit positions
  localparam int unsigned EVENT_W       = 6;
  localparam int unsigned EV_START      = 0;
  localparam int unsigned EV_STOP       = 1;
  localparam int unsigned EV_TOO_FREQ   = 2;
  localparam int unsigned EV_RUN_LONG   = 3;
  localparam int unsigned EV_FLOW_PULSE = 4;
  localparam int unsigned EV_BUTTON     = 5;

  // Three-sample history patterns (oldest sample in the MSB)
  localparam int unsigned HIST_W = 3;
  localparam logic [HIST_W-1:0] HIST_ALL_HIGH = 3'b111;
  localparam logic [HIST_W-1:0] HIST_ALL_LOW  = 3'b000;
  localparam logic [HIST_W-1:0] HIST_ROSE     = 3'b011;
  localparam logic [HIST_W-1:0] HIST_FELL     = 3'b100;

  // Run-timer value loaded at pump start
  localparam logic [TIMER_W-1:0] ON_TIMER_START = 24'd2;

endpackage

/* src/pump_relay_sequencer_and_monitor_unit.sv */
// Pump relay sequencer and monitor: one item per 10 ms tick.
// The result is registered and is valid in the cycle after the input is accepted.
// Throughput: one item per cycle; the input stays ready while the result
// register is empty or is being taken in the same cycle.
// Reset (rst_ni low, asynchronous): sequencer off, histories all ones, on timer
// and reported times cleared except the shortest on time, which with the off timer is all ones.
module pump_relay_sequencer_and_monitor_unit #(
  parameter int unsigned TIME_WIDTH = prsm_pkg::TIME_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [prsm_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [prsm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input item channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               flow_level_i,
  input  logic                               power_level_i,
  input  logic                               button_level_i,
  input  logic                               pump_request_i,
  // result item channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               relay_drive_o,
  output logic                               triac_gate_level_o,
  output logic                               pump_energized_o,
  output logic                               pump_running_o,
  output logic [prsm_pkg::EVENT_W-1:0]       event_flags_o,
  output logic [prsm_pkg::OUT_TIME_W-1:0]    run_time_since_pulse_o,
  output logic [prsm_pkg::OUT_TIME_W-1:0]    time_since_start_o,
  output logic [prsm_pkg::OUT_TIME_W-1:0]    longest_on_o,
  output logic [prsm_pkg::OUT_TIME_W-1:0]    shortest_on_o
);

  localparam int unsigned TW  = TIME_WIDTH;
  localparam int unsigned TMW = prsm_pkg::TIMER_W;
  localparam int unsigned HW  = prsm_pkg::HIST_W;

  typedef enum logic [2:0] {
    SEQ_OFF         = 3'd0,
    SEQ_TRIAC_MAKE  = 3'd1,
    SEQ_RELAY_MAKE  = 3'd2,
    SEQ_ON          = 3'd3,
    SEQ_TRIAC_BREAK = 3'd4,
    SEQ_RELAY_BREAK = 3'd5
  } seq_state_e;

  // Configuration registers
  logic [prsm_pkg::MARGIN_W-1:0] margin_q;
  logic [TMW-1:0]                min_stop_q;
  logic [TMW-1:0]                max_run_q;

  // Block state
  seq_state_e         seq_state_q, seq_state_d;
  logic [TW-1:0]      now_q;
  logic [TW-1:0]      seq_mark_q, seq_mark_d;
  logic               energized_q, energized_d;
  logic [HW-1:0]      flow_hist_q, flow_hist_d;
  logic [HW-1:0]      power_hist_q, power_hist_d;
  logic [HW-1:0]      button_hist_q, button_hist_d;
  logic [TMW-1:0]     on_timer_q, on_timer_d;
  logic [TMW-1:0]     off_timer_q, off_timer_d;
  logic               running_q, running_d;
  logic [TW-1:0]      on_acc_q, on_acc_d;
  logic [TW-1:0]      accum_start_q, accum_start_d;
  logic [TW-1:0]      pure_start_q, pure_start_d;
  logic [TW-1:0]      max_on_q, max_on_d;
  logic [TW-1:0]      min_on_q, min_on_d;
  logic [TW-1:0]      rep_acc_q, rep_acc_d;
  logic [TW-1:0]      rep_tss_q, rep_tss_d;
  logic [TW-1:0]      rep_max_q, rep_max_d;
  logic [TW-1:0]      rep_min_q, rep_min_d;

  // Result register
  logic                          out_valid_q;
  logic [prsm_pkg::EVENT_W-1:0]  events_q, events_d;

  // Shared arithmetic
  logic [TW-1:0]  margin_diff;
  logic           margin_passed;
  logic [TW-1:0]  acc_sum;
  logic [TW-1:0]  run_diff;

  // Sequencer side results
  logic           make_phase;
  logic           break_done;
  logic           energized_s;
  logic [TW-1:0]  max_on_s, min_on_s;
  logic [TMW-1:0] on_timer_inc;
  logic [TMW:0]   off_limit;

  logic accept;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign margin_diff   = now_q - seq_mark_q;
  assign margin_passed = margin_diff > TW'(margin_q);
  assign acc_sum       = on_acc_q + now_q - accum_start_q;
  assign run_diff      = now_q - pure_start_q;
  assign on_timer_inc  = on_timer_q + TMW'(1);
  assign off_limit     = {1'b0, min_stop_q} + (TMW+1)'(1);

  // Step the make/break sequencer
  always_comb begin
    seq_state_d  = seq_state_q;
    seq_mark_d   = seq_mark_q;
    energized_s  = energized_q;
    pure_start_d = pure_start_q;
    make_phase   = 1'b0;
    break_done   = 1'b0;
    max_on_s     = max_on_q;
    min_on_s     = min_on_q;
    unique case (seq_state_q)
      SEQ_OFF: begin
        if (pump_request_i) begin
          // fresh mark: margin cannot pass in this tick
          seq_mark_d   = now_q;
          seq_state_d  = SEQ_TRIAC_MAKE;
          energized_s  = 1'b1;
          pure_start_d = now_q;
          make_phase   = 1'b1;
        end
      end
      SEQ_TRIAC_MAKE: begin
        energized_s  = 1'b1;
        pure_start_d = now_q;
        make_phase   = 1'b1;
        if (margin_passed) begin
          seq_state_d = SEQ_RELAY_MAKE;
          seq_mark_d  = now_q;
        end
      end
      SEQ_RELAY_MAKE: begin
        if (margin_passed) begin
          seq_state_d = SEQ_ON;
        end
      end
      SEQ_ON: begin
        if (!pump_request_i) begin
          seq_mark_d  = now_q;
          seq_state_d = SEQ_TRIAC_BREAK;
        end
      end
      SEQ_TRIAC_BREAK: begin
        if (margin_passed) begin
          seq_state_d = SEQ_RELAY_BREAK;
          seq_mark_d  = now_q;
        end
      end
      SEQ_RELAY_BREAK: begin
        if (margin_passed) begin
          seq_state_d = SEQ_OFF;
          energized_s = 1'b0;
          break_done  = 1'b1;
        end
        if (run_diff > max_on_q) begin
          max_on_s = run_diff;
        end
        if (run_diff < min_on_q) begin
          min_on_s = run_diff;
        end
      end
      default: begin
        // unused codes behave like off
        seq_state_d = SEQ_OFF;
        if (pump_request_i) begin
          seq_mark_d   = now_q;
          seq_state_d  = SEQ_TRIAC_MAKE;
          energized_s  = 1'b1;
          pure_start_d = now_q;
          make_phase   = 1'b1;
        end
      end
    endcase
  end

  // Qualify inputs, flag events, update timers and reported times
  always_comb begin
    flow_hist_d   = {flow_hist_q[HW-2:0], flow_level_i};
    power_hist_d  = {power_hist_q[HW-2:0], power_level_i};
    button_hist_d = {button_hist_q[HW-2:0], button_level_i};

    events_d      = '0;
    energized_d   = energized_s;
    accum_start_d = make_phase ? now_q : accum_start_q;
    on_acc_d      = break_done ? acc_sum : on_acc_q;
    max_on_d      = max_on_s;
    min_on_d      = min_on_s;
    rep_acc_d     = rep_acc_q;
    rep_tss_d     = rep_tss_q;
    rep_max_d     = rep_max_q;
    rep_min_d     = rep_min_q;
    on_timer_d    = on_timer_q;
    off_timer_d   = off_timer_q;
    running_d     = running_q;

    if (button_hist_d == prsm_pkg::HIST_FELL) begin
      events_d[prsm_pkg::EV_BUTTON] = 1'b1;
    end

    // Flow pulse: latch the interval figures and restart the interval
    if (flow_hist_d == prsm_pkg::HIST_ROSE) begin
      if (break_done || (energized_s && !make_phase)) begin
        rep_acc_d = acc_sum;
      end else begin
        rep_acc_d = on_acc_q;
      end
      if (!energized_s) begin
        rep_tss_d = '0;
      end else if (make_phase || run_diff == '0) begin
        rep_tss_d = TW'(1);
      end else begin
        rep_tss_d = run_diff;
      end
      rep_max_d     = max_on_s;
      rep_min_d     = min_on_s;
      accum_start_d = now_q;
      on_acc_d      = '0;
      max_on_d      = '0;
      min_on_d      = '1;
      events_d[prsm_pkg::EV_FLOW_PULSE] = 1'b1;
    end

    // Power sense: start, run, stop, idle; bounce patterns hold
    case (power_hist_d)
      prsm_pkg::HIST_FELL: begin
        on_timer_d = prsm_pkg::ON_TIMER_START;
        events_d[prsm_pkg::EV_START] = 1'b1;
        if (off_timer_q < min_stop_q) begin
          events_d[prsm_pkg::EV_TOO_FREQ] = 1'b1;
        end
        running_d = 1'b1;
      end
      prsm_pkg::HIST_ALL_LOW: begin
        if (on_timer_q != '1) begin
          on_timer_d = on_timer_inc;
          if (on_timer_inc == max_run_q) begin
            events_d[prsm_pkg::EV_RUN_LONG] = 1'b1;
          end
        end
        running_d = 1'b1;
      end
      prsm_pkg::HIST_ROSE: begin
        events_d[prsm_pkg::EV_STOP] = 1'b1;
        off_timer_d = '0;
        running_d   = 1'b0;
      end
      prsm_pkg::HIST_ALL_HIGH: begin
        running_d = 1'b0;
        if (({1'b0, off_timer_q} < off_limit) && (off_timer_q != '1)) begin
          off_timer_d = off_timer_q + TMW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Take configuration writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q   <= prsm_pkg::MARGIN_RST;
      min_stop_q <= prsm_pkg::MIN_STOP_RST;
      max_run_q  <= prsm_pkg::MAX_RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        prsm_pkg::CFG_SWITCH_MARGIN: margin_q   <= cfg_data_i[prsm_pkg::MARGIN_W-1:0];
        prsm_pkg::CFG_MIN_STOP:      min_stop_q <= cfg_data_i[TMW-1:0];
        prsm_pkg::CFG_MAX_RUN:       max_run_q  <= cfg_data_i[TMW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold state and advance it on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q   <= SEQ_OFF;
      now_q         <= '0;
      seq_mark_q    <= '0;
      energized_q   <= 1'b0;
      flow_hist_q   <= prsm_pkg::HIST_ALL_HIGH;
      power_hist_q  <= prsm_pkg::HIST_ALL_HIGH;
      button_hist_q <= prsm_pkg::HIST_ALL_HIGH;
      on_timer_q    <= '0;
      off_timer_q   <= '1;
      running_q     <= 1'b0;
      on_acc_q      <= '0;
      accum_start_q <= '0;
      pure_start_q  <= '0;
      max_on_q      <= '0;
      min_on_q      <= '1;
      rep_acc_q     <= '0;
      rep_tss_q     <= '0;
      rep_max_q     <= '0;
      rep_min_q     <= '1;
      events_q      <= '0;
    end else if (accept) begin
      seq_state_q   <= seq_state_d;
      now_q         <= now_q + TW'(1);
      seq_mark_q    <= seq_mark_d;
      energized_q   <= energized_d;
      flow_hist_q   <= flow_hist_d;
      power_hist_q  <= power_hist_d;
      button_hist_q <= button_hist_d;
      on_timer_q    <= on_timer_d;
      off_timer_q   <= off_timer_d;
      running_q     <= running_d;
      on_acc_q      <= on_acc_d;
      accum_start_q <= accum_start_d;
      pure_start_q  <= pure_start_d;
      max_on_q      <= max_on_d;
      min_on_q      <= min_on_d;
      rep_acc_q     <= rep_acc_d;
      rep_tss_q     <= rep_tss_d;
      rep_max_q     <= rep_max_d;
      rep_min_q     <= rep_min_d;
      events_q      <= events_d;
    end
  end

  // Hold the result valid until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Drive result fields from the registered state
  always_comb begin
    relay_drive_o      = 1'b0;
    triac_gate_level_o = 1'b1;
    unique case (seq_state_q)
      SEQ_TRIAC_MAKE:  begin relay_drive_o = 1'b0; triac_gate_level_o = 1'b0; end
      SEQ_RELAY_MAKE:  begin relay_drive_o = 1'b1; triac_gate_level_o = 1'b0; end
      SEQ_ON:          begin relay_drive_o = 1'b1; triac_gate_level_o = 1'b1; end
      SEQ_TRIAC_BREAK: begin relay_drive_o = 1'b1; triac_gate_level_o = 1'b0; end
      SEQ_RELAY_BREAK: begin relay_drive_o = 1'b0; triac_gate_level_o = 1'b0; end
      default:         begin relay_drive_o = 1'b0; triac_gate_level_o = 1'b1; end
    endcase
  end

  assign out_valid_o            = out_valid_q;
  assign pump_energized_o       = energized_q;
  assign pump_running_o         = running_q;
  assign event_flags_o          = events_q;
  assign run_time_since_pulse_o = prsm_pkg::OUT_TIME_W'(rep_acc_q);
  assign time_since_start_o     = prsm_pkg::OUT_TIME_W'(rep_tss_q);
  assign longest_on_o           = prsm_pkg::OUT_TIME_W'(rep_max_q);
  assign shortest_on_o          = prsm_pkg::OUT_TIME_W'(rep_min_q);

endmodule

/* test/tb_pump_relay_sequencer_and_monitor_unit.sv */
module tb_pump_relay_sequencer_and_monitor_unit;

  // Sequencer codes, as the block steps through make and break
  typedef enum logic [2:0] {
    SEQ_OFF         = 3'd0,
    SEQ_TRIAC_MAKE  = 3'd1,
    SEQ_RELAY_MAKE  = 3'd2,
    SEQ_ON          = 3'd3,
    SEQ_TRIAC_BREAK = 3'd4,
    SEQ_RELAY_BREAK = 3'd5
  } seq_state_e;

  // Register index that maps to no register
  localparam logic [prsm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned MAX_REPORTED = 10;

  typedef logic [prsm_pkg::TIME_WIDTH_DEF-1:0] tick_t;

  typedef struct {
    logic                            relay;
    logic                            triac;
    logic                            energized;
    logic                            running;
    logic [prsm_pkg::EVENT_W-1:0]    events;
    logic [prsm_pkg::OUT_TIME_W-1:0] run_time;
    logic [prsm_pkg::OUT_TIME_W-1:0] since_start;
    logic [prsm_pkg::OUT_TIME_W-1:0] longest;
    logic [prsm_pkg::OUT_TIME_W-1:0] shortest;
  } tick_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [prsm_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [prsm_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic flow_level_i;
  logic power_level_i;
  logic button_level_i;
  logic pump_request_i;
  logic out_valid_o;
  logic out_ready_i;
  logic relay_drive_o;
  logic triac_gate_level_o;
  logic pump_energized_o;
  logic pump_running_o;
  logic [prsm_pkg::EVENT_W-1:0] event_flags_o;
  logic [prsm_pkg::OUT_TIME_W-1:0] run_time_since_pulse_o;
  logic [prsm_pkg::OUT_TIME_W-1:0] time_since_start_o;
  logic [prsm_pkg::OUT_TIME_W-1:0] longest_on_o;
  logic [prsm_pkg::OUT_TIME_W-1:0] shortest_on_o;

  // Pump model state, at its reset values
  logic [prsm_pkg::MARGIN_W-1:0] margin_cfg   = prsm_pkg::MARGIN_RST;
  logic [prsm_pkg::TIMER_W-1:0]  min_stop_cfg = prsm_pkg::MIN_STOP_RST;
  logic [prsm_pkg::TIMER_W-1:0]  max_run_cfg  = prsm_pkg::MAX_RUN_RST;
  tick_t                         clock_ticks  = '0;
  seq_state_e                    seq_q        = SEQ_OFF;
  tick_t                         seq_mark     = '0;
  logic                          energized    = 1'b0;
  logic [prsm_pkg::HIST_W-1:0]   flow_hist    = prsm_pkg::HIST_ALL_HIGH;
  logic [prsm_pkg::HIST_W-1:0]   power_hist   = prsm_pkg::HIST_ALL_HIGH;
  logic [prsm_pkg::HIST_W-1:0]   button_hist  = prsm_pkg::HIST_ALL_HIGH;
  logic [prsm_pkg::TIMER_W-1:0]  on_timer     = '0;
  logic [prsm_pkg::TIMER_W-1:0]  off_timer    = '1;
  logic                          running      = 1'b0;
  tick_t                         on_accum     = '0;
  tick_t                         accum_start  = '0;
  tick_t                         pure_start   = '0;
  tick_t                         max_on       = '0;
  tick_t                         min_on       = '1;
  tick_t                         rep_run      = '0;
  tick_t                         rep_since    = '0;
  tick_t                         rep_longest  = '0;
  tick_t                         rep_shortest = '1;

  tick_result_t pending_results[$];
  tick_result_t result_expected;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int items_sent         = 0;
  int results_checked    = 0;
  int fault_count        = 0;
  int event_seen[prsm_pkg::EVENT_W];

  pump_relay_sequencer_and_monitor_unit i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .flow_level_i           (flow_level_i),
    .power_level_i          (power_level_i),
    .button_level_i         (button_level_i),
    .pump_request_i         (pump_request_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .relay_drive_o          (relay_drive_o),
    .triac_gate_level_o     (triac_gate_level_o),
    .pump_energized_o       (pump_energized_o),
    .pump_running_o         (pump_running_o),
    .event_flags_o          (event_flags_o),
    .run_time_since_pulse_o (run_time_since_pulse_o),
    .time_since_start_o     (time_since_start_o),
    .longest_on_o           (longest_on_o),
    .shortest_on_o          (shortest_on_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Step only once more than the margin has elapsed since the last mark
  function automatic bit margin_elapsed(input tick_t now);
    tick_t elapsed;
    elapsed = now - seq_mark;
    return elapsed > tick_t'(margin_cfg);
  endfunction

  // Make/break sequencer; off falls into triac make, on falls into triac break
  function automatic void advance_sequencer(input logic req, input tick_t now);
    seq_state_e s;
    tick_t run;
    s = seq_q;
    if (s == SEQ_OFF) begin
      if (!req) return;
      seq_mark = now;
      s = SEQ_TRIAC_MAKE;
    end
    if (s == SEQ_TRIAC_MAKE) begin
      energized = 1'b1;
      pure_start = now;
      accum_start = now;
      if (margin_elapsed(now)) begin
        s = SEQ_RELAY_MAKE;
        seq_mark = now;
      end
      seq_q = s;
      return;
    end
    if (s == SEQ_RELAY_MAKE) begin
      if (margin_elapsed(now)) s = SEQ_ON;
      seq_q = s;
      return;
    end
    if (s == SEQ_ON) begin
      if (req) return;
      seq_mark = now;
      s = SEQ_TRIAC_BREAK;
    end
    if (s == SEQ_TRIAC_BREAK) begin
      if (margin_elapsed(now)) begin
        s = SEQ_RELAY_BREAK;
        seq_mark = now;
      end
      seq_q = s;
      return;
    end
    // relay break: finish the run and track its length
    if (margin_elapsed(now)) begin
      s = SEQ_OFF;
      energized = 1'b0;
      on_accum = on_accum + now - accum_start;
    end
    run = now - pure_start;
    if (run > max_on) max_on = run;
    if (run < min_on) min_on = run;
    seq_q = s;
  endfunction

  // Advance the pump model by one tick and return the result it produces
  function automatic tick_result_t predict_tick(input logic flow, power, button, req);
    tick_result_t r;
    tick_t now;
    tick_t since;
    now = clock_ticks;
    advance_sequencer(req, now);

    flow_hist   = {flow_hist[prsm_pkg::HIST_W-2:0], flow};
    power_hist  = {power_hist[prsm_pkg::HIST_W-2:0], power};
    button_hist = {button_hist[prsm_pkg::HIST_W-2:0], button};

    r.events = '0;
    if (button_hist == prsm_pkg::HIST_FELL) r.events[prsm_pkg::EV_BUTTON] = 1'b1;

    // Flow pulse: latch the interval figures and start a new interval
    if (flow_hist == prsm_pkg::HIST_ROSE) begin
      since = '0;
      if (energized) begin
        on_accum = on_accum + now - accum_start;
        since = now - pure_start;
        if (since == '0) since = tick_t'(1);
      end
      accum_start  = now;
      rep_run      = on_accum;
      rep_since    = since;
      rep_longest  = max_on;
      rep_shortest = min_on;
      on_accum     = '0;
      max_on       = '0;
      min_on       = '1;
      r.events[prsm_pkg::EV_FLOW_PULSE] = 1'b1;
    end

    // Qualified power sense; mixed histories are bounce and change nothing
    case (power_hist)
      prsm_pkg::HIST_FELL: begin
        on_timer = prsm_pkg::ON_TIMER_START;
        r.events[prsm_pkg::EV_START] = 1'b1;
        if (off_timer < min_stop_cfg) r.events[prsm_pkg::EV_TOO_FREQ] = 1'b1;
        running = 1'b1;
      end
      prsm_pkg::HIST_ALL_LOW: begin
        if (on_timer != '1) begin
          on_timer = on_timer + 1'b1;
          if (on_timer == max_run_cfg) r.events[prsm_pkg::EV_RUN_LONG] = 1'b1;
        end
        running = 1'b1;
      end
      prsm_pkg::HIST_ROSE: begin
        r.events[prsm_pkg::EV_STOP] = 1'b1;
        off_timer = '0;
        running = 1'b0;
      end
      prsm_pkg::HIST_ALL_HIGH: begin
        running = 1'b0;
        if (({1'b0, off_timer} < ({1'b0, min_stop_cfg} + 1'b1)) && (off_timer != '1))
          off_timer = off_timer + 1'b1;
      end
      default: ;
    endcase

    case (seq_q)
      SEQ_TRIAC_MAKE:  {r.relay, r.triac} = 2'b00;
      SEQ_RELAY_MAKE:  {r.relay, r.triac} = 2'b10;
      SEQ_ON:          {r.relay, r.triac} = 2'b11;
      SEQ_TRIAC_BREAK: {r.relay, r.triac} = 2'b10;
      SEQ_RELAY_BREAK: {r.relay, r.triac} = 2'b00;
      default:         {r.relay, r.triac} = 2'b01;
    endcase

    r.energized   = energized;
    r.running     = running;
    r.run_time    = rep_run[prsm_pkg::OUT_TIME_W-1:0];
    r.since_start = rep_since[prsm_pkg::OUT_TIME_W-1:0];
    r.longest     = rep_longest[prsm_pkg::OUT_TIME_W-1:0];
    r.shortest    = rep_shortest[prsm_pkg::OUT_TIME_W-1:0];
    clock_ticks   = clock_ticks + 1'b1;
    return r;
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_tick(input logic flow, power, button, req);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i     <= 1'b1;
    flow_level_i   <= flow;
    power_level_i  <= power;
    button_level_i <= button;
    pump_request_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_tick(flow, power, button, req));
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result, plus slack
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all three registers while idle, optionally poking the unused index
  task automatic set_registers(input logic [prsm_pkg::CFG_DATA_W-1:0] margin_word,
                               stop_word, run_word, input bit poke_unused);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= prsm_pkg::CFG_SWITCH_MARGIN;
    cfg_data_i  <= margin_word;
    @(posedge clk_i);
    cfg_index_i <= prsm_pkg::CFG_MIN_STOP;
    cfg_data_i  <= stop_word;
    @(posedge clk_i);
    cfg_index_i <= prsm_pkg::CFG_MAX_RUN;
    cfg_data_i  <= run_word;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_index_i <= CFG_UNUSED_INDEX;
      cfg_data_i  <= prsm_pkg::CFG_DATA_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    margin_cfg   = margin_word[prsm_pkg::MARGIN_W-1:0];
    min_stop_cfg = stop_word;
    max_run_cfg  = run_word;
  endtask

  // Idle ticks straight after reset show the report fields at their reset values
  task automatic test_reset_state();
    repeat (2) send_tick(1'b1, 1'b1, 1'b1, 1'b0);
  endtask

  // Fastest make and break with zero margin and zero timer limits
  task automatic test_fast_sequencer();
    set_registers('0, '0, '0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);  // triac make
    send_tick(1'b1, 1'b0, 1'b1, 1'b1);  // relay make
    send_tick(1'b1, 1'b0, 1'b1, 1'b1);  // on; pump start and flow pulse while energized
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);  // run timer counts
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);  // triac break
    send_tick(1'b0, 1'b1, 1'b1, 1'b0);  // relay break, bounce on power
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);  // off; pump stop
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);  // flow pulse reports longest and shortest run
  endtask

  // Widest margin stalls in triac make; then a narrow margin from a wide data word,
  // a too-frequent restart, run-too-long and a power glitch
  task automatic test_margin_and_limits();
    logic [7:0] power_pat;
    logic [7:0] req_pat;
    power_pat = 8'b0110_0001;
    req_pat   = 8'b1110_0000;
    set_registers(24'd255, 24'd16777214, 24'hFFFFFF, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b1);  // button press qualified here
    set_registers(24'hFFFF01, 24'd50, 24'd4, 1'b0);
    for (int k = 7; k >= 0; k--) send_tick(k[0], power_pat[k], 1'b1, req_pat[k]);
  endtask

  // Pump cycles with random content: request held, power follows with a lag,
  // flow toggling while pumping, occasional button presses and glitches
  task automatic test_random_pump_cycles(input int n_items, input int idle_pct,
                                         input int stall_pct);
    int sent;
    int on_len;
    int off_len;
    int lag;
    int noise;
    bit chaos;
    bit phys_on;
    bit flow_state;
    bit btn_level;
    logic req;
    logic f;
    logic p;
    logic b;
    set_registers(prsm_pkg::CFG_DATA_W'($urandom_range(0, 6)),
                  ($urandom_range(3) == 0) ? 24'd16777214 :
                      prsm_pkg::CFG_DATA_W'($urandom_range(0, 40)),
                  ($urandom_range(3) == 0) ? 24'd0 :
                      prsm_pkg::CFG_DATA_W'($urandom_range(1, 40)),
                  1'b0);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    noise      = $urandom_range(0, 6);
    flow_state = 1'b1;
    btn_level  = 1'b1;
    sent       = 0;
    while (sent < n_items) begin
      on_len  = $urandom_range(2, 45);
      off_len = $urandom_range(1, 25);
      lag     = $urandom_range(0, 3);
      chaos   = ($urandom_range(9) == 0);
      for (int t = 0; t < on_len + off_len && sent < n_items; t++) begin
        req = (t < on_len);
        if (chaos) begin
          f   = 1'($urandom_range(1));
          p   = 1'($urandom_range(1));
          b   = 1'($urandom_range(1));
          req = 1'($urandom_range(1));
        end else begin
          phys_on = (t >= lag) && (t < on_len + lag);
          if ($urandom_range(99) < (phys_on ? 35 : 5)) flow_state = !flow_state;
          if (btn_level) btn_level = !($urandom_range(99) < 6);
          else btn_level = ($urandom_range(99) < 40);
          f = flow_state ^ ($urandom_range(99) < noise);
          p = !phys_on ^ ($urandom_range(99) < noise);
          b = btn_level ^ ($urandom_range(99) < noise);
        end
        send_tick(f, p, b, req);
        sent++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTED)
      $display("mismatch %s on result %0d: expected %h, got %h",
               what, results_checked, want, got);
  endtask

  // Receiver: take results, stalling at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        result_expected = pending_results.pop_front();
        if (relay_drive_o !== result_expected.relay)
          report_mismatch("relay_drive", 32'(result_expected.relay), 32'(relay_drive_o));
        if (triac_gate_level_o !== result_expected.triac)
          report_mismatch("triac_gate_level", 32'(result_expected.triac),
                          32'(triac_gate_level_o));
        if (pump_energized_o !== result_expected.energized)
          report_mismatch("pump_energized", 32'(result_expected.energized),
                          32'(pump_energized_o));
        if (pump_running_o !== result_expected.running)
          report_mismatch("pump_running", 32'(result_expected.running),
                          32'(pump_running_o));
        if (event_flags_o !== result_expected.events)
          report_mismatch("event_flags", 32'(result_expected.events), 32'(event_flags_o));
        if (run_time_since_pulse_o !== result_expected.run_time)
          report_mismatch("run_time_since_pulse", result_expected.run_time,
                          run_time_since_pulse_o);
        if (time_since_start_o !== result_expected.since_start)
          report_mismatch("time_since_start", result_expected.since_start,
                          time_since_start_o);
        if (longest_on_o !== result_expected.longest)
          report_mismatch("longest_on", result_expected.longest, longest_on_o);
        if (shortest_on_o !== result_expected.shortest)
          report_mismatch("shortest_on", result_expected.shortest, shortest_on_o);
        for (int k = 0; k < prsm_pkg::EVENT_W; k++)
          event_seen[k] += int'(result_expected.events[k]);
      end
      results_checked++;
    end
  end

  // Hard stop if the run hangs
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int k = 0; k < prsm_pkg::EVENT_W; k++) event_seen[k] = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = prsm_pkg::CFG_SWITCH_MARGIN;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    flow_level_i   = 1'b0;
    power_level_i  = 1'b1;
    button_level_i = 1'b1;
    pump_request_i = 1'b0;
    out_ready_i    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_fast_sequencer();
    test_margin_and_limits();
    test_random_pump_cycles(225, 0, 0);
    test_random_pump_cycles(225, 84, 0);
    test_random_pump_cycles(225, 0, 84);
    test_random_pump_cycles(225, 21, 21);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fault_count += pending_results.size();
      $display("%0d predicted results never arrived", pending_results.size());
    end

    $display("summary: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, fault_count);
    $display("summary: starts %0d stops %0d too-frequent %0d run-long %0d pulses %0d presses %0d",
             event_seen[prsm_pkg::EV_START], event_seen[prsm_pkg::EV_STOP],
             event_seen[prsm_pkg::EV_TOO_FREQ], event_seen[prsm_pkg::EV_RUN_LONG],
             event_seen[prsm_pkg::EV_FLOW_PULSE], event_seen[prsm_pkg::EV_BUTTON]);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
